// ----- rtl/core/cauchy_pixel_flux_assert.svh -----
// Assertion macros for the Cauchy pixel flux block.
// Used by the port checker; relies on i_clk and i_rst_n in the including scope.
`ifndef CAUCHY_PIXEL_FLUX_ASSERT_SVH
`define CAUCHY_PIXEL_FLUX_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define CPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cauchy_pixel_flux check failed");

// Implication into the next cycle
`define CPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cauchy_pixel_flux check failed");

`endif

// ----- rtl/core/cpf_pkg.sv -----
// Shared widths, constants and the arctangent table for the Cauchy pixel flux block.
// No dependencies.
`default_nettype none

package cpf_pkg;

    // Field widths
    localparam int IW  = 24;          // offset fields, signed Q8.16
    localparam int GW  = 24;          // gamma register, unsigned Q8.16
    localparam int OW  = 25;          // flux fraction, Q1.24
    localparam int DIW = 48;          // input tdata width
    localparam int DOW = 32;          // output tdata width

    // Internal widths
    localparam int AW  = 26;          // corner coordinates 2x+-1 and 2*gamma, Q16
    localparam int SQW = 2 * AW;      // squares and products, Q32
    localparam int RW  = AW + 3;      // square root remainder
    localparam int XW  = 56;          // CORDIC x and y
    localparam int ZW  = 33;          // corner angle, 2^-32 turn
    localparam int SW  = 36;          // sum of four corner angles
    localparam int TW  = 30;          // arctangent table entry

    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [GW-1:0]        GAMMA_RESET = GW'(65536);
    localparam logic signed [AW-1:0] ONE_Q16     = AW'(65536);
    localparam logic [OW-1:0]        FLUX_ONE    = OW'(16777216);

    // atan(2^-i) in 2^-32 turn units, rounded to nearest
    function automatic logic [TW-1:0] cpf_atan(input logic [4:0] idx);
        logic [TW-1:0] v;
        case (idx)
            5'd0:    v = TW'(536870912);
            5'd1:    v = TW'(316933406);
            5'd2:    v = TW'(167458907);
            5'd3:    v = TW'(85004756);
            5'd4:    v = TW'(42667331);
            5'd5:    v = TW'(21354465);
            5'd6:    v = TW'(10679838);
            5'd7:    v = TW'(5340245);
            5'd8:    v = TW'(2670163);
            5'd9:    v = TW'(1335087);
            5'd10:   v = TW'(667544);
            5'd11:   v = TW'(333772);
            5'd12:   v = TW'(166886);
            5'd13:   v = TW'(83443);
            5'd14:   v = TW'(41722);
            5'd15:   v = TW'(20861);
            5'd16:   v = TW'(10430);
            5'd17:   v = TW'(5215);
            5'd18:   v = TW'(2608);
            5'd19:   v = TW'(1304);
            5'd20:   v = TW'(652);
            5'd21:   v = TW'(326);
            5'd22:   v = TW'(163);
            5'd23:   v = TW'(81);
            5'd24:   v = TW'(41);
            5'd25:   v = TW'(20);
            5'd26:   v = TW'(10);
            5'd27:   v = TW'(5);
            5'd28:   v = TW'(3);
            5'd29:   v = TW'(1);
            5'd30:   v = TW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cpf_corner.sv -----
// One corner term: square root of a^2+b^2+G^2, then CORDIC atan(a*b / (G*S)).
// Depends on cpf_pkg; fully pipelined, advances on i_en.
`default_nettype none

module cpf_corner import cpf_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [AW-1:0] i_b,
    input  wire logic [AW-1:0]        i_g,
    output logic signed [ZW-1:0]      o_angle
);

    localparam int NIT = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    logic signed [SQW-1:0] w_aa, w_bb, w_ab;
    logic [SQW-1:0]        w_gg;

    logic [SQW-1:0]        r_aa, r_bb, r_gg;
    logic signed [SQW-1:0] r_ab;
    logic [AW-1:0]         r_g1;

    logic [SQW-1:0]        r_rad  [0:AW];
    logic [RW-1:0]         r_rem  [0:AW];
    logic [AW-1:0]         r_root [0:AW];
    logic signed [SQW-1:0] r_sab  [0:AW];
    logic [AW-1:0]         r_sg   [0:AW];

    logic signed [XW-1:0]  r_cx [0:NIT];
    logic signed [XW-1:0]  r_cy [0:NIT];
    logic signed [ZW-1:0]  r_cz [0:NIT];

    logic [SQW-1:0]        w_xs;

    // Form the squares and the cross product
    assign w_aa = i_a * i_a;
    assign w_bb = i_b * i_b;
    assign w_ab = i_a * i_b;
    assign w_gg = i_g * i_g;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa <= w_aa;
            r_bb <= w_bb;
            r_gg <= w_gg;
            r_ab <= w_ab;
            r_g1 <= i_g;
        end
    end

    // Sum the squares into the radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= r_aa + r_bb + r_gg;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sab[0]  <= r_ab;
            r_sg[0]   <= r_g1;
        end
    end

    // Floor square root, one result bit per stage
    for (genvar k = 0; k < AW; k++) begin : g_sqrt
        logic [RW-1:0] w_cur, w_trial;
        assign w_cur   = {r_rem[k][RW-3:0], r_rad[k][SQW-1-2*k -: 2]};
        assign w_trial = {1'b0, r_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1] <= r_rad[k];
                r_sab[k+1] <= r_sab[k];
                r_sg[k+1]  <= r_sg[k];
                if (w_cur >= w_trial) begin
                    r_rem[k+1]  <= w_cur - w_trial;
                    r_root[k+1] <= {r_root[k][AW-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= w_cur;
                    r_root[k+1] <= {r_root[k][AW-2:0], 1'b0};
                end
            end
        end
    end

    // Scale the root by 2*gamma to get the CORDIC x input
    assign w_xs = r_sg[AW] * r_root[AW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= XW'(w_xs);
            r_cy[0] <= XW'(r_sab[AW]);
            r_cz[0] <= '0;
        end
    end

    // CORDIC vectoring, one rotation per stage
    for (genvar i = 0; i < NIT; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ANG = ZW'(cpf_atan(5'(i)));
        logic signed [XW-1:0] w_xsh, w_ysh;
        assign w_xsh = r_cx[i] >>> i;
        assign w_ysh = r_cy[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[i][XW-1]) begin
                    r_cx[i+1] <= r_cx[i] + w_ysh;
                    r_cy[i+1] <= r_cy[i] - w_xsh;
                    r_cz[i+1] <= r_cz[i] + ANG;
                end else begin
                    r_cx[i+1] <= r_cx[i] - w_ysh;
                    r_cy[i+1] <= r_cy[i] + w_xsh;
                    r_cz[i+1] <= r_cz[i] - ANG;
                end
            end
        end
    end

    assign o_angle = r_cz[NIT];

endmodule

`default_nettype wire

// ----- rtl/core/cauchy_pixel_flux.sv -----
// Top level of the Cauchy pixel flux block: stream ports, gamma register,
// four corner pipelines, sum, rounding and clamp. Depends on cpf_pkg, cpf_corner.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------
//  s (input) | in        | i_s_tvalid / o_s_tready | offset_x, offset_y
//  m (output)| out       | o_m_tvalid / i_m_tready | flux_fraction
//  cfg       | in        | i_cfg_valid/o_cfg_ready | gamma_width
//
// One item per cycle unless a result waits untaken; the pipeline depth is set by
// the 26 square-root stages and the CORDIC rotation stages of each corner.
// Reset clears the valid bits and loads gamma with 1.0.
// When the output is held and not taken, the whole pipeline holds in place.
`default_nettype none

module cauchy_pixel_flux import cpf_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire logic [DIW-1:0] i_s_tdata,   // [23:0] offset_x, [47:24] offset_y
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic [DOW-1:0]      o_m_tdata,   // [24:0] flux_fraction, rest zero
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [GW-1:0]  i_cfg_data   // gamma_width
);

    localparam int NIT = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int LC  = 3 + AW + NIT;
    localparam int LAT = 3 + LC;

    logic                 w_en;
    logic [GW-1:0]        r_gamma;
    logic [LAT-1:0]       r_vld;

    logic signed [IW-1:0] w_x, w_y;
    logic signed [AW-1:0] w_x2, w_y2;
    logic [GW-1:0]        w_geff;

    logic signed [AW-1:0] r_am, r_ap, r_bm, r_bp;
    logic [AW-1:0]        r_g;

    logic signed [ZW-1:0] w_z [0:3];
    logic signed [SW-1:0] r_sum;
    logic [SW-1:0]        w_rnd;
    logic [OW-1:0]        r_out;

    // Advance unless a result waits untaken
    assign w_en        = ~r_vld[LAT-1] | i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Gamma register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (i_cfg_valid) begin
            r_gamma <= i_cfg_data;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Corner coordinates 2x+-1, 2y+-1 and 2*gamma
    assign w_x    = i_s_tdata[IW-1:0];
    assign w_y    = i_s_tdata[2*IW-1:IW];
    assign w_x2   = {w_x[IW-1], w_x, 1'b0};
    assign w_y2   = {w_y[IW-1], w_y, 1'b0};
    assign w_geff = (r_gamma == '0) ? GW'(1) : r_gamma;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_am <= w_x2 - ONE_Q16;
            r_ap <= w_x2 + ONE_Q16;
            r_bm <= w_y2 - ONE_Q16;
            r_bp <= w_y2 + ONE_Q16;
            r_g  <= {1'b0, w_geff, 1'b0};
        end
    end

    cpf_corner #(.CORDIC_STEPS(CORDIC_STEPS)) u_c_mm (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_am), .i_b(r_bm), .i_g(r_g), .o_angle(w_z[0])
    );
    cpf_corner #(.CORDIC_STEPS(CORDIC_STEPS)) u_c_pm (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ap), .i_b(r_bm), .i_g(r_g), .o_angle(w_z[1])
    );
    cpf_corner #(.CORDIC_STEPS(CORDIC_STEPS)) u_c_mp (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_am), .i_b(r_bp), .i_g(r_g), .o_angle(w_z[2])
    );
    cpf_corner #(.CORDIC_STEPS(CORDIC_STEPS)) u_c_pp (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ap), .i_b(r_bp), .i_g(r_g), .o_angle(w_z[3])
    );

    // Sum the corners with alternating signs
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= SW'(w_z[0]) - SW'(w_z[1]) - SW'(w_z[2]) + SW'(w_z[3]);
        end
    end

    // Round to Q1.24 and clamp to 0..1
    assign w_rnd = SW'(r_sum) + SW'(128);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_sum[SW-1] || r_sum == '0) begin
                r_out <= '0;
            end else if (w_rnd[SW-1:8] > (SW-8)'(FLUX_ONE)) begin
                r_out <= FLUX_ONE;
            end else begin
                r_out <= OW'(w_rnd[SW-1:8]);
            end
        end
    end

    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = DOW'(r_out);

endmodule

`default_nettype wire

// ----- rtl/core/cpf_check.sv -----
// Port-level checker for the Cauchy pixel flux block, bound to the top level.
// Depends on cauchy_pixel_flux_assert.svh and cpf_pkg.
`default_nettype none

`include "cauchy_pixel_flux_assert.svh"

module cpf_check import cpf_pkg::*; (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_s_tvalid,
    input wire logic           o_s_tready,
    input wire logic [DIW-1:0] i_s_tdata,
    input wire logic           o_m_tvalid,
    input wire logic           i_m_tready,
    input wire logic [DOW-1:0] o_m_tdata,
    input wire logic           i_cfg_valid,
    input wire logic           o_cfg_ready,
    input wire logic [GW-1:0]  i_cfg_data
);

    // A held result blocks new input
    `CPF_ASSERT_IMP(a_stall_blocks_input, o_m_tvalid && !i_m_tready, !o_s_tready)
    // Result never exceeds one and padding stays zero
    `CPF_ASSERT_IMP(a_flux_range, o_m_tvalid, o_m_tdata[DOW-1:OW] == '0 &&
        (!o_m_tdata[OW-1] || o_m_tdata[OW-2:0] == '0))
    // A stalled result holds its value
    `CPF_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // Free output means free input
    `CPF_ASSERT_IMP(a_ready_free, !o_m_tvalid, o_s_tready && o_cfg_ready)

endmodule

bind cauchy_pixel_flux cpf_check u_cpf_check (.*);

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the Cauchy pixel flux block: drives pixel offsets over the stream port,
// predicts the flux fraction per pixel and checks every output transfer in order.
// Depends on cpf_pkg and the cauchy_pixel_flux RTL.
`default_nettype none

module testbench import cpf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int LATENCY     = 6 + 26 + STEPS;
    localparam int RANDOM_PIX  = 500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NO_CHECK    = -1;

    typedef struct {
        logic signed [IW-1:0] x;
        logic signed [IW-1:0] y;
        int                   known;   // typed-in expectation, or NO_CHECK
    } t_pixel;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_s_tvalid;
    logic           o_s_tready;
    logic [DIW-1:0] i_s_tdata;
    logic           o_m_tvalid;
    logic           i_m_tready;
    logic [DOW-1:0] o_m_tdata;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [GW-1:0]  i_cfg_data;

    logic [GW-1:0]  gamma_q;
    logic [DOW-1:0] flux_queue[$];
    int             errors;
    int             cycles;
    bit             src_no_gaps;
    bit             sink_no_gaps;
    bit             sink_hold;

    cauchy_pixel_flux u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Arithmetic shift right, rounding toward minus infinity
    function automatic longint shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Corner arctangent in 2^-32 turn units by CORDIC vectoring
    function automatic longint corner_angle(longint a, longint b, longint g2);
        longint unsigned s2;
        longint          xv, yv, xs, ys, z;
        s2 = longint'(a * a) + longint'(b * b) + longint'(g2 * g2);
        xv = g2 * root_floor(s2);
        yv = a * b;
        z  = 0;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = shr(xv, i);
            ys = shr(yv, i);
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                z  = z + longint'(cpf_atan(5'(i)));
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                z  = z - longint'(cpf_atan(5'(i)));
            end
        end
        return z;
    endfunction

    function automatic logic [DOW-1:0] pixel_flux(logic signed [IW-1:0] px,
                                                  logic signed [IW-1:0] py,
                                                  logic [GW-1:0] gw);
        longint x, y, g2, am, ap, bm, bp, total, r;
        x  = longint'(px);
        y  = longint'(py);
        g2 = 2 * ((gw == 0) ? 64'd1 : longint'(gw));
        am = 2 * x - 65536;
        ap = 2 * x + 65536;
        bm = 2 * y - 65536;
        bp = 2 * y + 65536;
        total = corner_angle(am, bm, g2) - corner_angle(ap, bm, g2)
              - corner_angle(am, bp, g2) + corner_angle(ap, bp, g2);
        if (total <= 0) begin
            r = 0;
        end else begin
            r = (total + 128) >>> 8;
            if (r > longint'(FLUX_ONE)) r = longint'(FLUX_ONE);
        end
        return DOW'(r);
    endfunction

    // Offer one pixel; record its expected flux when the transfer happens
    task automatic send_pixel(t_pixel p);
        logic [DOW-1:0] want;
        while (!src_no_gaps && $urandom_range(99) < 21) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        want = pixel_flux(p.x, p.y, gamma_q);
        if (p.known != NO_CHECK && want != DOW'(p.known)) begin
            $display("%0t typed expectation differs: expected %0d actual %0d",
                     $time, p.known, want);
            errors++;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {p.y, p.x};
        do @(posedge i_clk); while (!o_s_tready);
        flux_queue.push_back(want);
    endtask

    task automatic drain_pipe();
        i_s_tvalid <= 1'b0;
        while (flux_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_gamma(logic [GW-1:0] gw);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= gw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gamma_q = gw;
    endtask

    function automatic logic signed [IW-1:0] rand_offset();
        case ($urandom_range(3))
            0:       return IW'($urandom);
            1:       return IW'($signed($urandom_range(1310720)) - 655360);
            default: return IW'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    // Check each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (flux_queue.size() == 0) begin
                $display("%0t unexpected flux transfer: expected none actual %0d",
                         $time, o_m_tdata);
                errors++;
            end else begin
                if (o_m_tdata !== flux_queue[0]) begin
                    $display("%0t flux mismatch: expected %0d actual %0d",
                             $time, flux_queue[0], o_m_tdata);
                    errors++;
                end
                void'(flux_queue.pop_front());
            end
        end
    end

    // Randomly stall the output side, with a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !sink_hold && (sink_no_gaps || $urandom_range(99) >= 21);
        end
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_pixel directed[12];
        t_pixel p;
        logic [GW-1:0] gamma_list[5];

        errors = 0;
        cycles = 0;
        src_no_gaps = 1'b0;
        sink_no_gaps = 1'b0;
        sink_hold = 1'b0;
        gamma_q = GAMMA_RESET;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: centre, extremes of both fields, neighbors, far corners
        directed = '{
            '{x: 0,             y: 0,             known: NO_CHECK},
            '{x: 24'sh7FFFFF,   y: 24'sh7FFFFF,   known: NO_CHECK},
            '{x: -24'sh800000,  y: -24'sh800000,  known: NO_CHECK},
            '{x: 24'sh7FFFFF,   y: -24'sh800000,  known: NO_CHECK},
            '{x: -24'sh800000,  y: 24'sh7FFFFF,   known: NO_CHECK},
            '{x: 65536,         y: 0,             known: NO_CHECK},
            '{x: 0,             y: -65536,        known: NO_CHECK},
            '{x: -65536,        y: 65536,         known: NO_CHECK},
            '{x: 32768,         y: 32768,         known: NO_CHECK},
            '{x: 24'shFFFFFF,   y: 1,             known: NO_CHECK},
            '{x: 24'sh555555,   y: 24'shAAAAAA,   known: NO_CHECK},
            '{x: 24'shAAAAAA,   y: 24'sh555555,   known: NO_CHECK}
        };
        foreach (directed[i]) send_pixel(directed[i]);

        // Narrowest width (zero taken as one LSB), then the widest
        drain_pipe();
        write_gamma('0);
        foreach (directed[i]) send_pixel(directed[i]);
        p = '{x: 24'sh7FFFFF, y: 24'sh7FFFFF, known: 0};
        send_pixel(p);
        drain_pipe();
        write_gamma(24'hFFFFFF);
        foreach (directed[i]) send_pixel(directed[i]);

        // Long output hold-off while pixels keep coming
        drain_pipe();
        write_gamma(GAMMA_RESET);
        fork
            begin
                sink_hold = 1'b1;
                repeat (3 * LATENCY) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            begin
                src_no_gaps = 1'b1;
                repeat (2 * LATENCY) begin
                    p = '{x: rand_offset(), y: rand_offset(), known: NO_CHECK};
                    send_pixel(p);
                end
                src_no_gaps = 1'b0;
            end
        join

        // Random phases over several widths, one phase without gaps
        gamma_list = '{24'd1, 24'd16384, 24'd65536, 24'd300000, 24'hFFFFFF};
        for (int ph = 0; ph < 5; ph++) begin
            drain_pipe();
            write_gamma(ph == 3 ? GW'($urandom_range(1, 24'hFFFFFF)) : gamma_list[ph]);
            src_no_gaps = (ph == 2);
            sink_no_gaps = (ph == 2);
            repeat (RANDOM_PIX / 5) begin
                p = '{x: rand_offset(), y: rand_offset(), known: NO_CHECK};
                send_pixel(p);
            end
        end
        src_no_gaps = 1'b0;
        sink_no_gaps = 1'b0;

        drain_pipe();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire
